// File: rtl/atq_pkg.sv
// ----------------------------------------------------------------------------
// atq_pkg
// shared types and constants of the alarm timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package atq_pkg;

	// field widths
	localparam int SLOT_W    = 3;
	localparam int TIMEOUT_W = 32;
	localparam int CNT_W     = 33;   // two's complement count and key

	// the slot field reaches eight slots at most
	localparam int MAX_SLOTS = 8;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_TICK_START = 3'd0;

	// command codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SWEEP,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// File: rtl/atq_ram.sv
// ----------------------------------------------------------------------------
// atq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module atq_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/atq_div.sv
// ----------------------------------------------------------------------------
// atq_div
// division by a fixed divisor through a reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module atq_div #(
	parameter int DIVISOR_VAL = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [atq_pkg::TIMEOUT_W-1:0]  dividend,
	output logic                                done,
	output logic      [atq_pkg::TIMEOUT_W-1:0]  quotient
);

	localparam int W   = atq_pkg::TIMEOUT_W;
	localparam int L   = $clog2(DIVISOR_VAL);
	localparam int SH1 = (L > 0) ? 1 : 0;
	localparam int SH2 = (L > 1) ? (L - 1) : 0;
	localparam logic [63:0] P2L   = 64'd1 << L;
	// m = floor(2^W * (2^L - d) / d) + 1, always below 2^W
	localparam logic [63:0] RECIP = (((64'd1 << W) * (P2L - 64'(DIVISOR_VAL)))
	                                 / 64'(DIVISOR_VAL)) + 64'd1;
	localparam logic [W-1:0] RECIP_C = RECIP[W-1:0];

	logic           v1_s1;
	logic           v2_s2;
	logic           done_q;
	logic [W-1:0]   n_s1;
	logic [W-1:0]   n_s2;
	logic [W-1:0]   t1_s2;
	logic [W-1:0]   quot_q;

	logic [2*W-1:0] prod;
	logic [W-1:0]   diff;
	logic [W-1:0]   sum;

	// high half of the product, then fix-up add and shift
	assign prod = 64'(n_s1) * 64'(RECIP_C);
	assign diff = n_s2 - t1_s2;
	assign sum  = t1_s2 + (diff >> SH1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1  <= 1'b0;
			v2_s2  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v1_s1  <= start;
			v2_s2  <= v1_s1;
			done_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_s1 <= dividend;
		end
		if (v1_s1) begin
			n_s2  <= n_s1;
			t1_s2 <= prod[2*W-1:W];
		end
		if (v2_s2) begin
			quot_q <= sum >> SH2;
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

// File: rtl/alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// alarm_timer_queue
// alarm table held in one ram; ticks count every armed slot down and emit
// expired slots in ascending key order
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                  | beat payload
//  --------+-----+----------------------------+------------------------------
//  input   | in  | in_valid / in_stall        | cmd, alarm_slot, timeout
//  output  | out | out_valid / out_stall      | fired_slot, last_fired
//  config  | in  | psel, penable, pwrite      | paddr, pwdata (tick_start)
//
//  set beat with nonzero timeout: the divider runs its steps
//  (reciprocal multiply, then add and shift) before the slot entry is written
//  cancel or out-of-range set beat: taken without leaving the idle state
//  tick beat: a sweep over the S ram entries, then a scan and an emission
//  per expired slot, or a bare scan when none expired; S = min(NUM_ALARMS, 8)
//  is the slot count; each emission rescans the ram for the least key
//  reset clears the armed and pending bits among other registers, not the ram;
//  entries are used only once written, so the ram needs no clearing pass
//  a stalled output holds the sequencer in the emit state; the next input
//  beat is taken as soon as the last result of a tick sits in the output
//  register
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_timer_queue #(
	parameter int NUM_ALARMS    = 8,
	parameter int TIMEOUT_SCALE = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [atq_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [atq_pkg::PDATA_W-1:0]         pwdata,
	output logic      [atq_pkg::PDATA_W-1:0]         prdata,
	output logic                                     pready,
	// command beats
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                cmd,
	input  wire logic [atq_pkg::SLOT_W-1:0]          alarm_slot,
	input  wire logic [atq_pkg::TIMEOUT_W-1:0]       timeout,
	// fired-slot beats
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic      [atq_pkg::SLOT_W-1:0]          fired_slot,
	output logic                                     last_fired
);

	localparam int SLOTS  = (NUM_ALARMS < atq_pkg::MAX_SLOTS) ? NUM_ALARMS
	                        : atq_pkg::MAX_SLOTS;
	localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW     = $clog2(SLOTS + 1);
	localparam int KW     = atq_pkg::CNT_W;
	localparam int TW     = atq_pkg::TIMEOUT_W;
	localparam int SW     = atq_pkg::SLOT_W;
	localparam int RAM_W  = 2 * KW;

	localparam logic [IW-1:0]    SLOTS_C = IW'(SLOTS);
	localparam logic [SW:0]      SLOTS_V = (SW + 1)'(SLOTS);
	localparam logic [SLOTS-1:0] ONE_V   = SLOTS'(1);
	localparam logic [KW-1:0]    SCALE_V = KW'(TIMEOUT_SCALE);

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	atq_pkg::state_t state_q, state_d;

	logic [TW-1:0]    tick_start_q;
	logic [SLOTS-1:0] armed_q;      // slot holds a live alarm
	logic [SLOTS-1:0] pend_q;       // expired on this tick, not yet emitted
	logic [IW-1:0]    idx_q;        // sweep / scan address counter

	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;

	logic             best_vld_q;
	logic [AW-1:0]    best_slot_q;
	logic [KW-1:0]    best_key_q;

	logic [AW-1:0]    set_slot_q;
	logic [TW-1:0]    set_key_q;

	logic             out_valid_q;
	logic [SW-1:0]    fired_q;
	logic             last_q;

	// ------------------------------------------------------------------
	// decode
	// ------------------------------------------------------------------
	logic             cfg_wr;
	logic             in_acc;
	logic             slot_ok;
	logic             arm_req;
	logic             out_free;
	logic             pend_left;

	logic [RAM_W-1:0] rd_data_s1;
	logic [KW-1:0]    rd_left_s1, rd_key_s1;
	logic [KW-1:0]    left_dec, key_dec;
	logic             expired;
	logic             better;

	logic             ram_rd_en;
	logic             ram_wr_en;
	logic [AW-1:0]    ram_wr_addr;
	logic [RAM_W-1:0] ram_wr_data;
	logic             wb_en;
	logic             div_start;
	logic             div_done;
	logic [TW-1:0]    div_quot;
	logic             out_load;

	assign cfg_wr    = psel && penable && pwrite && (paddr == atq_pkg::ADDR_TICK_START);
	assign in_acc    = in_valid && !in_stall;
	assign slot_ok   = ({1'b0, alarm_slot} < SLOTS_V);
	assign arm_req   = in_acc && (cmd == atq_pkg::CMD_SET) && slot_ok && (timeout != '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign pend_left = ((pend_q & ~(ONE_V << best_slot_q)) != '0);

	assign rd_left_s1 = rd_data_s1[RAM_W-1:KW];
	assign rd_key_s1  = rd_data_s1[KW-1:0];
	assign left_dec   = rd_left_s1 - 1'b1;
	assign key_dec    = rd_key_s1 - SCALE_V;
	// remaining count at or below zero after the decrement
	assign expired    = left_dec[KW-1] || (left_dec == '0);
	assign better     = !best_vld_q || ($signed(rd_key_s1) < $signed(best_key_q));

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			atq_pkg::ST_IDLE: begin
				if (in_acc && (cmd == atq_pkg::CMD_TICK)) begin
					state_d = atq_pkg::ST_SWEEP;
				end else if (arm_req) begin
					state_d = atq_pkg::ST_DIV;
				end
			end
			atq_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = atq_pkg::ST_IDLE;
				end
			end
			atq_pkg::ST_SWEEP: begin
				if (idx_q == SLOTS_C) begin
					state_d = atq_pkg::ST_SCAN;
				end
			end
			atq_pkg::ST_SCAN: begin
				if (pend_q == '0) begin
					state_d = atq_pkg::ST_IDLE;
				end else if (idx_q == SLOTS_C) begin
					state_d = atq_pkg::ST_EMIT;
				end
			end
			atq_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = pend_left ? atq_pkg::ST_SCAN : atq_pkg::ST_IDLE;
				end
			end
			default: state_d = atq_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// state outputs
	// ------------------------------------------------------------------
	always_comb begin
		in_stall  = 1'b1;
		ram_rd_en = 1'b0;
		wb_en     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			atq_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				div_start = arm_req;
			end
			atq_pkg::ST_DIV: begin
			end
			atq_pkg::ST_SWEEP: begin
				ram_rd_en = (idx_q != SLOTS_C);
				wb_en     = rd_vld_s1 && armed_q[rd_idx_s1];
			end
			atq_pkg::ST_SCAN: begin
				ram_rd_en = (idx_q != SLOTS_C);
			end
			atq_pkg::ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	// the set write lands only in the divide state, the write-back only in
	// the sweep, and the sweep writes entry i-1 while reading entry i, so
	// no read ever meets a write to the same entry
	always_comb begin
		if (state_q == atq_pkg::ST_DIV) begin
			ram_wr_en   = div_done;
			ram_wr_addr = set_slot_q;
			ram_wr_data = {1'b0, div_quot, 1'b0, set_key_q};
		end else begin
			ram_wr_en   = wb_en;
			ram_wr_addr = rd_idx_s1;
			ram_wr_data = {left_dec, key_dec};
		end
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= atq_pkg::ST_IDLE;
			tick_start_q <= '0;
			armed_q      <= '0;
			pend_q       <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			best_vld_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_rd_en;

			// counter restarts on every pass
			if ((state_q == atq_pkg::ST_SWEEP || state_q == atq_pkg::ST_SCAN)
			    && (idx_q != SLOTS_C)) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end

			// reinit disarms everything
			if (cfg_wr) begin
				tick_start_q <= pwdata;
				armed_q      <= '0;
			end else if (in_acc && (cmd == atq_pkg::CMD_SET) && slot_ok) begin
				armed_q[alarm_slot[AW-1:0]] <= 1'b0;
			end else if ((state_q == atq_pkg::ST_DIV) && div_done) begin
				armed_q[set_slot_q] <= 1'b1;
			end else if (out_load) begin
				armed_q[best_slot_q] <= 1'b0;
			end

			if (wb_en) begin
				pend_q[rd_idx_s1] <= expired;
			end else if (out_load) begin
				pend_q[best_slot_q] <= 1'b0;
			end

			// running minimum over the pending slots
			if (out_load) begin
				best_vld_q <= 1'b0;
			end else if ((state_q == atq_pkg::ST_SCAN) && rd_vld_s1
			             && pend_q[rd_idx_s1] && better) begin
				best_vld_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if ((state_q == atq_pkg::ST_SCAN) && rd_vld_s1 && pend_q[rd_idx_s1] && better) begin
			best_slot_q <= rd_idx_s1;
			best_key_q  <= rd_key_s1;
		end
		if (arm_req) begin
			set_slot_q <= alarm_slot[AW-1:0];
			set_key_q  <= timeout;
		end
		if (out_load) begin
			fired_q <= SW'(best_slot_q);
			last_q  <= !pend_left;
		end
	end

	// ------------------------------------------------------------------
	// alarm entry store: {ticks_left, order_key}
	// ------------------------------------------------------------------
	atq_ram #(
		.WIDTH (RAM_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data_s1)
	);

	// timeout to remaining ticks
	atq_div #(
		.DIVISOR_VAL (TIMEOUT_SCALE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (timeout),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign prdata     = tick_start_q;
	assign pready     = 1'b1;
	assign out_valid  = out_valid_q;
	assign fired_slot = fired_q;
	assign last_fired = last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_pend_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~armed_q) == '0)
		else $error("pending slot is not armed");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == atq_pkg::ST_IDLE |-> pend_q == '0)
		else $error("expired slots left behind after a tick");

	a_emit_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == atq_pkg::ST_EMIT |-> best_vld_q && pend_q[best_slot_q])
		else $error("emit without a pending minimum");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == atq_pkg::ST_EMIT))
		else $error("result appeared outside the emit state");

endmodule

`default_nettype wire

// File: test/alarm_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// alarm_timer_queue_tb
// self-checking bench for the alarm timer queue: a scoreboard class keeps its
// own alarm table and tick counter, predicts the fired-slot beats of every
// accepted tick and checks each output beat in order against them; plain
// tasks drive the command channel and the apb port, with random idling on
// both sides, a long output hold-off and several tick_start settings
// ----------------------------------------------------------------------------
module alarm_timer_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_SLOTS   = 8;
	localparam int SCALE       = 64;
	localparam int MAX_FIRED   = 8;
	localparam int HOLD_CYCLES = 300;   // long output hold-off
	localparam int SETTLE      = 100;   // quiet cycles after the last beat
	localparam int LIMIT_NS    = 2_000_000;

	// unused register index 1 sits at byte address 4
	localparam logic [atq_pkg::PADDR_W-1:0] ADDR_UNUSED = 3'd4;

	// one expected output beat
	typedef struct packed {
		logic [atq_pkg::SLOT_W-1:0] slot;
		logic                       last;
	} firing_t;

	// ------------------------------------------------------------------------
	// scoreboard: alarm table model plus the queue of fired slots still due
	// ------------------------------------------------------------------------
	class fired_slot_board;
		logic [31:0]               tick_count;
		logic                      armed [NUM_SLOTS];
		logic [atq_pkg::CNT_W-1:0] left [NUM_SLOTS];   // remaining ticks
		logic [atq_pkg::CNT_W-1:0] key [NUM_SLOTS];    // sort key
		firing_t                   fired_due [$];
		int                        errors;

		function new();
			errors = 0;
			foreach (left[i]) begin
				left[i] = '0;
				key[i]  = '0;
			end
			restart(32'd0);
		endfunction

		// tick_start write: counter reloaded, whole table disarmed
		function void restart(logic [31:0] start);
			tick_count = start;
			foreach (armed[i]) armed[i] = 1'b0;
		endfunction

		// an accepted command beat
		function void note_beat(logic c, logic [atq_pkg::SLOT_W-1:0] s,
				logic [atq_pkg::TIMEOUT_W-1:0] t);
			int      best;
			int      n;
			firing_t f;
			if (c == atq_pkg::CMD_SET) begin
				if (s < NUM_SLOTS) begin
					armed[s] = 1'b0;
					if (t != '0) begin
						left[s]  = atq_pkg::CNT_W'(t / SCALE);
						key[s]   = atq_pkg::CNT_W'(t);
						armed[s] = 1'b1;
					end
				end
				return;
			end
			tick_count = tick_count + 32'd1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (armed[i]) begin
					left[i] = left[i] - atq_pkg::CNT_W'(1);
					key[i]  = key[i] - atq_pkg::CNT_W'(SCALE);
				end
			end
			n = 0;
			do begin
				best = -1;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (armed[i] && $signed(left[i]) <= 0) begin
						if (best < 0 || $signed(key[i]) < $signed(key[best]))
							best = i;
					end
				end
				if (best >= 0) begin
					armed[best] = 1'b0;
					f.slot = best[atq_pkg::SLOT_W-1:0];
					f.last = 1'b0;
					fired_due.push_back(f);
					n++;
				end
			end while (best >= 0 && n < MAX_FIRED);
			if (n > 0)
				fired_due[fired_due.size()-1].last = 1'b1;
		endfunction

		// an accepted output beat
		function void check_beat(logic [atq_pkg::SLOT_W-1:0] s, logic l);
			firing_t f;
			if (fired_due.size() == 0) begin
				$error("fired_slot %0d arrived with no expiry due", s);
				errors++;
				return;
			end
			f = fired_due.pop_front();
			if (s !== f.slot) begin
				$error("fired_slot expected %0d got %0d", f.slot, s);
				errors++;
			end
			if (l !== f.last) begin
				$error("last_fired expected %0d got %0d", f.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return fired_due.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------------
	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [atq_pkg::PADDR_W-1:0]   paddr;
	logic [atq_pkg::PDATA_W-1:0]   pwdata;
	logic [atq_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_stall;
	logic                          cmd;
	logic [atq_pkg::SLOT_W-1:0]    alarm_slot;
	logic [atq_pkg::TIMEOUT_W-1:0] timeout;
	logic                          out_valid;
	logic                          out_stall;
	logic [atq_pkg::SLOT_W-1:0]    fired_slot;
	logic                          last_fired;

	fired_slot_board board;
	bit              calm;           // no idling on either side while set
	bit              hold_req;       // sender asks the receiver for a hold-off
	int              hold_left;
	logic [31:0]     last_timeout;   // reused now and then to force key ties

	alarm_timer_queue #(
		.NUM_ALARMS   (NUM_SLOTS),
		.TIMEOUT_SCALE(SCALE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.alarm_slot(alarm_slot),
		.timeout   (timeout),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fired_slot(fired_slot),
		.last_fired(last_fired)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(LIMIT_NS);
		$display("** alarm_timer_queue: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: checks every accepted output beat, then picks the stall for
	// the next cycle; a hold-off request keeps stall high for a long count
	// ------------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				board.check_beat(fired_slot, last_fired);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 24);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender tasks; all called right after a rising edge
	// ------------------------------------------------------------------------

	// offer one beat and hold it until accepted
	task automatic send_item(input logic c, input logic [atq_pkg::SLOT_W-1:0] s,
			input logic [atq_pkg::TIMEOUT_W-1:0] t);
		in_valid   <= 1'b1;
		cmd        <= c;
		alarm_slot <= s;
		timeout    <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_beat(c, s, t);
	endtask

	task automatic idle(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// drop valid, wait for every due beat, then let the block finish any
	// set or empty tick still in flight
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic [atq_pkg::PADDR_W-1:0] a,
			input logic [atq_pkg::PDATA_W-1:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (a == atq_pkg::ADDR_TICK_START)
			board.restart(d);
	endtask

	// random beats: ticks and sets, the sets mostly with short timeouts so that
	// ticks fire often, plus cancels, full-range timeouts, repeated timeouts for
	// key ties and timeouts on a scale boundary
	task automatic run_phase(input int count, input int hold_at, input int pause_at);
		int                            r;
		int                            q;
		logic [atq_pkg::TIMEOUT_W-1:0] t;
		for (int k = 0; k < count; k++) begin
			if (k == hold_at) begin
				// hold-off while a tick that expires slots 0 to 3 is lined up behind it
				hold_req = 1'b1;
				for (int s = 0; s < 4; s++)
					send_item(atq_pkg::CMD_SET, atq_pkg::SLOT_W'(s),
						$urandom_range(1, 63));
				send_item(atq_pkg::CMD_TICK, '0, '0);
			end
			if (k == pause_at) begin
				// sender waits out every due beat
				in_valid <= 1'b0;
				@(posedge clk);
				while (board.pending() != 0) @(posedge clk);
			end
			if (!calm && $urandom_range(0, 99) < 24)
				idle($urandom_range(1, 4));
			r = $urandom_range(0, 99);
			if (r < 35) begin
				send_item(atq_pkg::CMD_TICK, atq_pkg::SLOT_W'($urandom_range(0, 7)),
					$urandom);
			end else begin
				q = $urandom_range(0, 99);
				if (q < 60)
					t = $urandom_range(1, 5 * SCALE);
				else if (q < 70)
					t = '0;
				else if (q < 80)
					t = $urandom;
				else if (q < 90)
					t = last_timeout;
				else
					t = $urandom_range(0, 3) * SCALE;
				last_timeout = t;
				send_item(atq_pkg::CMD_SET, atq_pkg::SLOT_W'($urandom_range(0, 7)), t);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		board        = new();
		calm         = 1'b0;
		hold_req     = 1'b0;
		last_timeout = 32'd1;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		cmd          = atq_pkg::CMD_TICK;
		alarm_slot   = '0;
		timeout      = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// --- directed part, tick_start at its reset value ---
		// tick on an empty table, cancel of an idle slot
		send_item(atq_pkg::CMD_TICK, '0, '0);
		send_item(atq_pkg::CMD_SET, 3'd0, '0);
		// largest timeout, then cancelled again
		send_item(atq_pkg::CMD_SET, 3'd7, 32'hFFFF_FFFF);
		send_item(atq_pkg::CMD_SET, 3'd7, '0);
		// all eight slots expire on one tick; slots 1 and 3 tie on the key
		send_item(atq_pkg::CMD_SET, 3'd0, 32'd100);
		send_item(atq_pkg::CMD_SET, 3'd1, 32'd5);
		send_item(atq_pkg::CMD_SET, 3'd2, 32'd63);
		send_item(atq_pkg::CMD_SET, 3'd3, 32'd5);
		send_item(atq_pkg::CMD_SET, 3'd4, 32'd1);
		send_item(atq_pkg::CMD_SET, 3'd5, 32'd127);
		send_item(atq_pkg::CMD_SET, 3'd6, 32'd64);
		send_item(atq_pkg::CMD_SET, 3'd7, 32'd90);
		send_item(atq_pkg::CMD_TICK, 3'd7, 32'hFFFF_FFFF);
		// expiries spread over later ticks, one slot re-armed while armed
		send_item(atq_pkg::CMD_SET, 3'd2, 32'd200);
		send_item(atq_pkg::CMD_SET, 3'd5, 32'd150);
		send_item(atq_pkg::CMD_SET, 3'd2, 32'd210);
		send_item(atq_pkg::CMD_TICK, '0, '0);
		send_item(atq_pkg::CMD_TICK, '0, '0);
		send_item(atq_pkg::CMD_TICK, '0, '0);
		// far-off alarm: tick with nothing due, then cancel
		send_item(atq_pkg::CMD_SET, 3'd4, 32'hFFFF_FFC0);
		send_item(atq_pkg::CMD_TICK, '0, '0);
		send_item(atq_pkg::CMD_SET, 3'd4, '0);
		// armed slots left behind for the next register write to clear
		send_item(atq_pkg::CMD_SET, 3'd3, 32'd10);
		send_item(atq_pkg::CMD_SET, 3'd6, 32'hFFFF_FFFF);
		settle();

		// --- counter about to wrap; armed slots are dropped by the write ---
		apb_write(atq_pkg::ADDR_TICK_START, 32'hFFFF_FFFF);
		apb_write(ADDR_UNUSED, $urandom);
		send_item(atq_pkg::CMD_TICK, '0, '0);
		calm = 1'b1;
		run_phase(75, -1, -1);
		calm = 1'b0;
		settle();

		// --- long output hold-off ---
		apb_write(atq_pkg::ADDR_TICK_START, 32'h8000_0000);
		run_phase(75, 20, -1);
		settle();

		// --- sender pause until drained ---
		apb_write(atq_pkg::ADDR_TICK_START, $urandom);
		run_phase(75, -1, 30);
		settle();

		// --- back to zero ---
		apb_write(atq_pkg::ADDR_TICK_START, 32'd0);
		run_phase(75, -1, -1);
		settle();

		if (board.errors == 0 && board.pending() == 0)
			$display("** alarm_timer_queue: PASSED **");
		else
			$display("** alarm_timer_queue: FAILED **");
		$finish;
	end

endmodule

// File: alarm_timer_queue.f
rtl/atq_pkg.sv
rtl/atq_ram.sv
rtl/atq_div.sv
rtl/alarm_timer_queue.sv
test/alarm_timer_queue_tb.sv
